/* sv/rc4sc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared types and constants of the rc4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

  // table geometry
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TableD = 256;
  localparam int unsigned AddrW  = 8;

  // key length register
  localparam int unsigned       KeyLenW     = 6;
  localparam logic [KeyLenW-1:0] KeyLenReset = 6'd16;

  // function codes of an input transaction
  localparam logic FUNC_REKEY   = 1'b0;
  localparam logic FUNC_ENCRYPT = 1'b1;

  // configuration register indexes
  localparam int unsigned  CfgIdxW = 3;
  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] CFG_KEY_LENGTH = 3'd4;
  localparam int unsigned CfgDataW = 64;

  // input transaction payload
  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] data_in;
    logic             last_in;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic [ByteW-1:0] data_out;
    logic             last_out;
  } out_t;

  // result handed from the engine to the output register
  typedef struct packed {
    logic valid;
    out_t item;
  } res_t;

  // one access to the permutation memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

/* sv/rc4sc_perm_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4sc_perm_mem
// 256 x 8 permutation memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4sc_perm_mem
  import rc4sc_pkg::*;
(
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem [TableD];
  logic [ByteW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered, old data on same-cycle write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rc4sc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4sc_ctrl
// Sequencer for key schedule and keystream steps over the permutation memory.
// ----------------------------------------------------------------------------
module rc4sc_ctrl
  import rc4sc_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  in_t                                 in_data_i,
  output logic                                in_stall_o,
  input  logic [MAX_KEY_BYTES-1:0][ByteW-1:0] key_i,
  input  logic [KeyLenW-1:0]                  key_len_i,
  input  logic                                out_free_i,
  output res_t                                res_o,
  output mem_req_t                            mem_req_o,
  input  logic [ByteW-1:0]                    mem_rdata_i
);

  localparam int unsigned KidxW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef enum logic [3:0] {
    StIdle,
    StFill,
    StKRdN,
    StKRdJ,
    StKWrN,
    StKWrJ,
    StERdJ,
    StESwap,
    StEOut,
    StEHold
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] n_q, n_d;
  logic [KidxW-1:0] kidx_q, kidx_d;
  logic [AddrW-1:0] i_q, i_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [ByteW-1:0] a_q, a_d;
  logic [ByteW-1:0] b_q, b_d;
  logic             hit_i_q, hit_i_d;
  logic             hit_j_q, hit_j_d;
  logic [ByteW-1:0] data_q, data_d;
  logic             last_q, last_d;
  out_t             hold_q, hold_d;

  logic [AddrW-1:0] j_ksa;
  logic [AddrW-1:0] j_prga;
  logic [AddrW-1:0] t_idx;
  logic [ByteW-1:0] ks;
  logic             kidx_wrap;

  // datapath terms
  assign j_ksa     = j_q + key_i[kidx_q] + mem_rdata_i;
  assign j_prga    = j_q + mem_rdata_i;
  assign t_idx     = a_q + mem_rdata_i;
  assign kidx_wrap = (KeyLenW'(kidx_q) + KeyLenW'(1)) == key_len_i;
  assign ks        = hit_j_q ? a_q : (hit_i_q ? b_q : mem_rdata_i);

  assign in_stall_o = (state_q != StIdle);

  // next state, memory access and result
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    kidx_d    = kidx_q;
    i_d       = i_q;
    j_d       = j_q;
    a_d       = a_q;
    b_d       = b_q;
    hit_i_d   = hit_i_q;
    hit_j_d   = hit_j_q;
    data_d    = data_q;
    last_d    = last_q;
    hold_d    = hold_q;
    mem_req_o = '0;
    res_o     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          data_d = in_data_i.data_in;
          last_d = in_data_i.last_in;
          if (in_data_i.func == FUNC_ENCRYPT) begin
            i_d             = i_q + AddrW'(1);
            mem_req_o.raddr = i_q + AddrW'(1);
            state_d         = StERdJ;
          end else begin
            n_d     = '0;
            state_d = StFill;
          end
        end
      end
      // identity fill
      StFill: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = n_q;
        mem_req_o.wdata = n_q;
        n_d             = n_q + AddrW'(1);
        if (n_q == AddrW'(TableD - 1)) begin
          kidx_d  = '0;
          j_d     = '0;
          state_d = StKRdN;
        end
      end
      // key schedule: read S[n]
      StKRdN: begin
        mem_req_o.raddr = n_q;
        state_d         = StKRdJ;
      end
      // key schedule: advance j, read S[j]
      StKRdJ: begin
        a_d             = mem_rdata_i;
        j_d             = j_ksa;
        mem_req_o.raddr = j_ksa;
        state_d         = StKWrN;
      end
      // key schedule: S[n] gets old S[j]
      StKWrN: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = n_q;
        mem_req_o.wdata = mem_rdata_i;
        state_d         = StKWrJ;
      end
      // key schedule: S[j] gets old S[n], next position
      StKWrJ: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = a_q;
        n_d             = n_q + AddrW'(1);
        kidx_d          = kidx_wrap ? '0 : kidx_q + KidxW'(1);
        if (n_q == AddrW'(TableD - 1)) begin
          i_d     = '0;
          j_d     = '0;
          state_d = StIdle;
        end else begin
          state_d = StKRdN;
        end
      end
      // keystream: advance j, read S[j]
      StERdJ: begin
        a_d             = mem_rdata_i;
        j_d             = j_prga;
        mem_req_o.raddr = j_prga;
        state_d         = StESwap;
      end
      // keystream: S[i] gets old S[j], read S[t] with forwarding flags
      StESwap: begin
        b_d             = mem_rdata_i;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = i_q;
        mem_req_o.wdata = mem_rdata_i;
        mem_req_o.raddr = t_idx;
        hit_i_d         = (t_idx == i_q);
        hit_j_d         = (t_idx == j_q);
        state_d         = StEOut;
      end
      // keystream: S[j] gets old S[i], produce result
      StEOut: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = a_q;
        hold_d.data_out = data_q ^ ks;
        hold_d.last_out = last_q;
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.item  = hold_d;
          state_d     = StIdle;
        end else begin
          state_d = StEHold;
        end
      end
      // result waits for the output register
      StEHold: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.item  = hold_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    kidx_q  <= kidx_d;
    a_q     <= a_d;
    b_q     <= b_d;
    hit_i_q <= hit_i_d;
    hit_j_q <= hit_j_d;
    data_q  <= data_d;
    last_q  <= last_d;
    hold_q  <= hold_d;
  end

endmodule

/* sv/rc4_stream_cipher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top
// RC4 cipher: key registers, sequencer over a 256 x 8 table, output register.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o   in_t  (func, data_in, last_in)
// out       output     out_valid_o/out_stall_i out_t (data_out, last_out)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// an encrypt transaction reaches the output register after one state per dependent
// table read (S[i], S[j], S[t]); the next is accepted once the sequencer is idle again
// a rekey transaction keeps in_stall_o high after acceptance for 256 identity writes,
// then 4 table accesses per position
// reset clears indices and key registers (key length 16); the table is undefined
// until the first rekey; a stalled output holds one result while the sequencer waits
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top
  import rc4sc_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  in_t                 in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output out_t                out_data_o,
  input  logic                out_stall_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [KeyLenW-1:0] MaxLen = KeyLenW'(MAX_KEY_BYTES);

  logic [MAX_KEY_BYTES-1:0][ByteW-1:0] key_q;
  logic [KeyLenW-1:0]                  key_len_q;
  logic [KeyLenW-1:0]                  key_len_eff;
  logic                                out_valid_q;
  out_t                                out_q;
  logic                                out_free;
  res_t                                res;
  mem_req_t                            mem_req;
  logic [ByteW-1:0]                    mem_rdata;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= KeyLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i) inside
        CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3: begin
          for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            if (2'(b >> 3) == cfg_index_i[1:0]) begin
              key_q[b] <= cfg_data_i[ByteW*(b & 7) +: ByteW];
            end
          end
        end
        CFG_KEY_LENGTH: begin
          key_len_q <= cfg_data_i[KeyLenW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // zero length acts as one, long keys saturate
  always_comb begin
    if (key_len_q == '0) begin
      key_len_eff = KeyLenW'(1);
    end else if (key_len_q > MaxLen) begin
      key_len_eff = MaxLen;
    end else begin
      key_len_eff = key_len_q;
    end
  end

  rc4sc_perm_mem u_perm_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rc4sc_ctrl #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .key_i       (key_q),
    .key_len_i   (key_len_eff),
    .out_free_i  (out_free),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rc4_stream_cipher_top. It programs the key registers
// through the config port, sends rekey and encrypt transactions, and tracks
// the expected cipher bytes in its own model of the permutation table and its
// two indices. Each output transaction is checked against the oldest pending
// byte. Both the sender and the receiver stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import rc4sc_pkg::*;

  localparam int unsigned KeyBytesMax   = 32;
  localparam int unsigned KeyWords      = 4;
  localparam int unsigned BytesPerWord  = CfgDataW / ByteW;
  // settle wait after a drain, long enough for a rekey to finish
  localparam int unsigned SettleCycles  = 1400;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomItems   = 1200;
  localparam int unsigned CalmItems     = 150;

  typedef enum logic [1:0] {KEY_ZERO, KEY_ONES, KEY_RANDOM} key_fill_e;

  // dut ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_t                 in_data_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_t                out_data_o;
  logic                out_stall_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // cipher state as the bench sees it
  logic [ByteW-1:0]    sbox [TableD];
  logic [ByteW-1:0]    idx_i;
  logic [ByteW-1:0]    idx_j;
  logic [CfgDataW-1:0] key_word [KeyWords];
  logic [KeyLenW-1:0]  key_len;

  // pending cipher bytes, oldest first
  out_t expected_bytes [$];
  out_t want;

  bit          idle_en       = 1'b1;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned rekeys_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned key_loads     = 0;

  rc4_stream_cipher_top #(
    .MAX_KEY_BYTES(KeyBytesMax)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // key schedule: identity table, then 256 swaps with j summing key bytes
  function automatic void schedule_key();
    int unsigned      len;
    int unsigned      k;
    logic [ByteW-1:0] j;
    logic [ByteW-1:0] kb;
    logic [ByteW-1:0] tmp;
    len = (key_len == 0) ? 1 : (key_len > KeyBytesMax) ? KeyBytesMax : key_len;
    for (int n = 0; n < TableD; n++) sbox[n] = ByteW'(n);
    j = '0;
    for (int n = 0; n < TableD; n++) begin
      k   = n % len;
      kb  = key_word[k / BytesPerWord][ByteW * (k % BytesPerWord) +: ByteW];
      j   = j + kb + sbox[n];
      tmp = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // one keystream step xored into the data byte
  function automatic out_t encrypt_byte(input in_t item);
    out_t             res;
    logic [ByteW-1:0] tmp;
    logic [ByteW-1:0] t;
    idx_i = idx_i + 1'b1;
    idx_j = idx_j + sbox[idx_i];
    tmp = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    t = sbox[idx_i] + sbox[idx_j];
    res.data_out = item.data_in ^ sbox[t];
    res.last_out = item.last_in;
    return res;
  endfunction

  // rekey with junk in the ignored fields
  function automatic in_t rekey_item();
    in_t it;
    it.func    = FUNC_REKEY;
    it.data_in = ByteW'($urandom);
    it.last_in = 1'($urandom);
    return it;
  endfunction

  function automatic in_t byte_item(input logic [ByteW-1:0] data, input logic last);
    in_t it;
    it.func    = FUNC_ENCRYPT;
    it.data_in = data;
    it.last_in = last;
    return it;
  endfunction

  // send one input transaction and predict what it causes
  task automatic send_item(input in_t item);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.func == FUNC_REKEY) begin
      schedule_key();
      rekeys_sent++;
    end else begin
      expected_bytes.push_back(encrypt_byte(item));
    end
    items_sent++;
  endtask

  // one register write; the caller lowers cfg_valid_i after its last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= CFG_KEY_WORD_3) begin
      key_word[idx] = val;
    end else if (idx == CFG_KEY_LENGTH) begin
      key_len = val[KeyLenW-1:0];
    end
  endtask

  // all four key words and the length, junk above the length field
  task automatic load_key(input key_fill_e fill, input logic [KeyLenW-1:0] len);
    logic [CfgDataW-1:0] w;
    for (int k = 0; k < KeyWords; k++) begin
      case (fill)
        KEY_ZERO: w = '0;
        KEY_ONES: w = '1;
        default:  w = {$urandom, $urandom};
      endcase
      write_reg(CfgIdxW'(CFG_KEY_WORD_0 + k), w);
    end
    w = {$urandom, $urandom};
    w[KeyLenW-1:0] = len;
    write_reg(CFG_KEY_LENGTH, w);
    cfg_valid_i <= 1'b0;
    key_loads++;
  endtask

  // hold the sender until every pending byte is back, optionally let a rekey finish
  task automatic drain(input bit settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
    if (settle) repeat (SettleCycles) @(posedge clk_i);
  endtask

  // reset key, data extremes, both last values
  task automatic test_default_key();
    send_item(rekey_item());
    send_item(byte_item(8'h00, 1'b0));
    send_item(byte_item(8'hFF, 1'b1));
    send_item(byte_item(8'h80, 1'b0));
    send_item(byte_item(8'h01, 1'b1));
  endtask

  // length zero, one, full, and values past the maximum
  task automatic test_key_length_edges();
    int unsigned len_cases [5] = '{0, 1, KeyBytesMax, KeyBytesMax + 1, 2**KeyLenW - 1};
    for (int c = 0; c < 5; c++) begin
      drain(1'b1);
      load_key((c == 2) ? KEY_ONES : KEY_RANDOM, KeyLenW'(len_cases[c]));
      send_item(rekey_item());
      send_item(byte_item(ByteW'($urandom), 1'b0));
      send_item(byte_item(ByteW'($urandom), 1'b1));
    end
  endtask

  // writes past the last register index change nothing; back-to-back rekeys
  task automatic test_ignored_indices();
    drain(1'b1);
    for (int k = CFG_KEY_LENGTH + 1; k < 2**CfgIdxW; k++) begin
      write_reg(CfgIdxW'(k), {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
    send_item(rekey_item());
    send_item(rekey_item());
    send_item(byte_item(ByteW'($urandom), 1'b0));
    send_item(byte_item(ByteW'($urandom), 1'b1));
  endtask

  // messages under random keys, with stray rekeys and odd last flags
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned msg_len;
    logic [KeyLenW-1:0] len;
    key_fill_e fill;
    logic last;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      idle_en = (target - items_sent > CalmItems);
      drain(1'b1);
      if ($urandom_range(0, 9) == 0) len = KeyLenW'($urandom_range(0, 2**KeyLenW - 1));
      else len = KeyLenW'($urandom_range(1, KeyBytesMax));
      case ($urandom_range(0, 9))
        0:       fill = KEY_ZERO;
        1:       fill = KEY_ONES;
        default: fill = KEY_RANDOM;
      endcase
      load_key(fill, len);
      // now and then keep running on the old table
      if ($urandom_range(0, 9) != 0) send_item(rekey_item());
      repeat ($urandom_range(2, 6)) begin
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
        for (int b = 0; b < msg_len; b++) begin
          if ($urandom_range(0, 24) == 0) send_item(rekey_item());
          last = (b == msg_len - 1);
          if ($urandom_range(0, 19) == 0) last = ~last;
          send_item(byte_item(ByteW'($urandom), last));
        end
        if ($urandom_range(0, 7) == 0) drain(1'b0);
        if ($urandom_range(0, 3) == 0) send_item(rekey_item());
      end
    end
  endtask

  // output check and receiver stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: data_out %0h last_out %0b",
                 out_data_o.data_out, out_data_o.last_out);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_o.data_out !== want.data_out) begin
            $error("data_out: expected %0h, actual %0h", want.data_out, out_data_o.data_out);
            fail_count++;
          end
          if (out_data_o.last_out !== want.last_out) begin
            $error("last_out: expected %0b, actual %0b", want.last_out, out_data_o.last_out);
            fail_count++;
          end
        end
        results_seen++;
      end
      if (stall_left != 0) stall_left--;
      else if (idle_en && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    key_word = '{default: '0};
    key_len  = KeyLenReset;
    idx_i    = '0;
    idx_j    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_key();
    test_key_length_edges();
    test_ignored_indices();
    test_random_traffic();
    drain(1'b1);
    $display("sent %0d transactions (%0d rekeys), checked %0d bytes under %0d key settings",
             items_sent, rekeys_sent, results_seen, key_loads);
    $display("covered key lengths 0 to 63, unused register indexes and random stalls");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
